// ----- src/cdt_pkg.sv -----
// Shared constants and types for the degree-input cosine pipeline.
`default_nettype none
package cdt_pkg;

    localparam int unsigned TERMS = 21;

    localparam logic [31:0] DEG360_Q16 = 32'd360 << 16;
    localparam logic [31:0] DEG270_Q16 = 32'd270 << 16;
    localparam logic [31:0] DEG180_Q16 = 32'd180 << 16;
    localparam logic [31:0] DEG90_Q16  = 32'd90 << 16;

    // Number of conditional subtractions needed to reduce a 32-bit angle
    localparam int unsigned MOD_STEPS = 8;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_PER_DEG_FULL = (PI_Q60 >> 14) / 64'd180;
    localparam logic [40:0] RAD_PER_DEG = RAD_PER_DEG_FULL[40:0];

    localparam logic [31:0] ONE_Q30 = 32'd1 << 30;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

    localparam int unsigned ACC_W = 36;

    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic [31:0]             term;
        logic [31:0]             x2;
        logic signed [ACC_W-1:0] acc;
    } cdt_lane_t;

endpackage
`default_nettype wire

// ----- src/cdt_reduce.sv -----
// Modulo-360 reduction and first-quadrant folding of a Q16.16 angle.
`default_nettype none
module cdt_reduce
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [31:0] angle,
    output logic             out_valid,
    output logic             out_neg,
    output logic [22:0]      out_m
);

    logic [31:0] m_reg [0:cdt_pkg::MOD_STEPS];
    logic        v_reg [0:cdt_pkg::MOD_STEPS];
    logic [31:0] m_next [0:cdt_pkg::MOD_STEPS];
    logic [31:0] fold;
    logic        fold_neg;
    logic        valid_reg;
    logic        neg_reg;
    logic [22:0] m_out_reg;

    assign m_next[0] = angle;

    // Binary long division by 360 degrees: one shifted subtraction per stage
    for (genvar i = 0; i < cdt_pkg::MOD_STEPS; i++) begin : g_mod
        localparam logic [31:0] SUB = cdt_pkg::DEG360_Q16 << (cdt_pkg::MOD_STEPS - 1 - i);
        always_comb
        begin
            if (m_reg[i] >= SUB)
            begin
                m_next[i+1] = m_reg[i] - SUB;
            end
            else
            begin
                m_next[i+1] = m_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= cdt_pkg::MOD_STEPS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < cdt_pkg::MOD_STEPS; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= m_next[0];
        for (int i = 0; i < cdt_pkg::MOD_STEPS; i++)
        begin
            m_reg[i+1] <= m_next[i+1];
        end
    end

    always_comb
    begin
        fold     = m_reg[cdt_pkg::MOD_STEPS];
        fold_neg = 1'b0;
        if (fold >= cdt_pkg::DEG270_Q16)
        begin
            fold = cdt_pkg::DEG360_Q16 - fold;
        end
        if (fold >= cdt_pkg::DEG180_Q16)
        begin
            fold     = fold - cdt_pkg::DEG180_Q16;
            fold_neg = 1'b1;
        end
        if (fold >= cdt_pkg::DEG90_Q16)
        begin
            fold     = cdt_pkg::DEG180_Q16 - fold;
            fold_neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= v_reg[cdt_pkg::MOD_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= fold_neg;
        m_out_reg <= fold[22:0];
    end

    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_m     = m_out_reg;

endmodule
`default_nettype wire

// ----- src/cdt_rad.sv -----
// Degrees to radians in Q2.30 and the squared angle.
`default_nettype none
module cdt_rad
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_neg,
    input  wire logic [22:0] m,
    output logic             out_valid,
    output logic             out_neg,
    output logic [31:0]      x2
);

    logic [2:0]  v_reg;
    logic [2:0]  neg_reg;
    logic [43:0] plo_reg;
    logic [42:0] phi_reg;
    logic [63:0] r62;
    logic [31:0] r30_next;
    logic [31:0] r30_reg;
    logic [63:0] sq;
    logic [31:0] x2_reg;

    always_comb
    begin
        r62      = {21'd0, phi_reg} << 21;
        r62      = r62 + {20'd0, plo_reg};
        r30_next = r62[63:32] + {31'd0, r62[31]};
        sq       = {32'd0, r30_reg} * {32'd0, r30_reg} + cdt_pkg::HALF_Q30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= {neg_reg[1:0], in_neg};
        // split the 41-bit constant into two narrow products
        plo_reg <= {21'd0, m} * {23'd0, cdt_pkg::RAD_PER_DEG[20:0]};
        phi_reg <= {20'd0, m} * {23'd0, cdt_pkg::RAD_PER_DEG[40:21]};
        r30_reg <= r30_next;
        x2_reg  <= sq[61:30];
    end

    assign out_valid = v_reg[2];
    assign out_neg   = neg_reg[2];
    assign x2        = x2_reg;

endmodule
`default_nettype wire

// ----- src/cdt_term.sv -----
// One series term: scale by x^2, divide by (2n-1)(2n) and accumulate.
`default_nettype none
module cdt_term
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [11:0]       k,
    input  wire logic [32:0]       rcp,
    input  wire logic [5:0]        shf,
    input  wire logic              odd,
    input  wire cdt_pkg::cdt_lane_t lane_in,
    output cdt_pkg::cdt_lane_t     lane_out
);

    cdt_pkg::cdt_lane_t a_reg;
    cdt_pkg::cdt_lane_t b_reg;
    cdt_pkg::cdt_lane_t c_reg;
    logic [63:0] prod_a;
    logic [33:0] p_reg;
    logic [33:0] v_next;
    logic [66:0] prod_b;
    logic [66:0] q0_full;
    logic [33:0] v_reg;
    logic [33:0] q0_reg;
    logic [45:0] qk;
    logic [45:0] rem;
    logic [33:0] q;
    logic signed [cdt_pkg::ACC_W-1:0] q_s;

    always_comb
    begin
        prod_a  = {32'd0, lane_in.term} * {32'd0, lane_in.x2} + cdt_pkg::HALF_Q30;
        v_next  = p_reg + {23'd0, k[11:1]};
        prod_b  = {33'd0, v_next} * {34'd0, rcp};
        q0_full = prod_b >> shf;
        qk      = {12'd0, q0_reg} * {34'd0, k};
        rem     = {12'd0, v_reg} - qk;
        // reciprocal estimate is at most one short
        if (rem >= {34'd0, k})
        begin
            q = q0_reg + 34'd1;
        end
        else
        begin
            q = q0_reg;
        end
        q_s = signed'({{(cdt_pkg::ACC_W-34){1'b0}}, q});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            a_reg <= lane_in;
            b_reg <= a_reg;
            c_reg.valid <= b_reg.valid;
            c_reg.neg   <= b_reg.neg;
            c_reg.x2    <= b_reg.x2;
            c_reg.term  <= q[31:0];
            if (odd)
            begin
                c_reg.acc <= b_reg.acc - q_s;
            end
            else
            begin
                c_reg.acc <= b_reg.acc + q_s;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= prod_a[63:30];
        v_reg  <= v_next;
        q0_reg <= q0_full[33:0];
    end

    assign lane_out = c_reg;

endmodule
`default_nettype wire

// ----- src/cosine_degrees_taylor_top.sv -----
// Top level of the pipelined degree-input cosine.
// Takes one Q16.16 angle on any cycle with start high (busy is always low) and gives its
// Q2.30 cosine on cosine with done high at the end of the pipeline, whose depth is set by the
// modulo stages, the fold and radian stages, three stages per series term and the output register.
// Results arrive in order, one per accepted angle, and cannot be held off.
`default_nettype none
module cosine_degrees_taylor_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] angle_degrees,
    output logic             done,
    output logic signed [31:0] cosine
);

    localparam int unsigned NT = cdt_pkg::TERMS - 1;

    logic        red_valid;
    logic        red_neg;
    logic [22:0] red_m;
    logic        rad_valid;
    logic        rad_neg;
    logic [31:0] rad_x2;
    cdt_pkg::cdt_lane_t lane [0:NT];
    logic signed [cdt_pkg::ACC_W-1:0] acc;
    logic signed [31:0] clamped;
    logic signed [31:0] cos_next;
    logic        done_reg;
    logic signed [31:0] cos_reg;

    assign busy = 1'b0;

    cdt_reduce u_reduce
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .angle     (angle_degrees),
        .out_valid (red_valid),
        .out_neg   (red_neg),
        .out_m     (red_m)
    );

    cdt_rad u_rad
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_neg    (red_neg),
        .m         (red_m),
        .out_valid (rad_valid),
        .out_neg   (rad_neg),
        .x2        (rad_x2)
    );

    always_comb
    begin
        lane[0].valid = rad_valid;
        lane[0].neg   = rad_neg;
        lane[0].x2    = rad_x2;
        lane[0].term  = cdt_pkg::ONE_Q30;
        lane[0].acc   = signed'({{(cdt_pkg::ACC_W-32){1'b0}}, cdt_pkg::ONE_Q30});
    end

    for (genvar i = 0; i < NT; i++) begin : g_term
        localparam int unsigned N  = i + 1;
        localparam int unsigned KN = (2 * N - 1) * (2 * N);
        localparam int unsigned SC = $clog2(KN);
        localparam logic [63:0] RN = (64'd1 << (32 + SC)) / KN;
        localparam logic [63:0] SN = 64'd32 + SC;
        localparam logic [63:0] KV = KN;
        localparam logic [63:0] OV = N % 2;
        cdt_term u_term
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .k        (KV[11:0]),
            .rcp      (RN[32:0]),
            .shf      (SN[5:0]),
            .odd      (OV[0]),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    // Clamp to [0, 1] then apply the quadrant sign
    always_comb
    begin
        acc = lane[NT].acc;
        if (acc < 0)
        begin
            clamped = 32'sd0;
        end
        else if (acc > signed'({{(cdt_pkg::ACC_W-32){1'b0}}, cdt_pkg::ONE_Q30}))
        begin
            clamped = signed'(cdt_pkg::ONE_Q30);
        end
        else
        begin
            clamped = acc[31:0];
        end
        if (lane[NT].neg)
        begin
            cos_next = -clamped;
        end
        else
        begin
            cos_next = clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lane[NT].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
    end

    assign done   = done_reg;
    assign cosine = cos_reg;

endmodule
`default_nettype wire

// ----- tb/cosine_checker.sv -----
// Checker: predicts the cosine of each accepted angle and compares it with done words.
module cosine_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [31:0]        angle_degrees,
    input  logic               done,
    input  logic signed [31:0] cosine,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cdt_pkg::*;

    logic signed [31:0] cosine_due_q[$];

    function automatic logic signed [31:0] predict_cosine(logic [31:0] angle);
        logic [63:0]        folded;
        logic               negate;
        logic [63:0]        rad_k;
        logic [127:0]       rad62;
        logic [63:0]        rad30;
        logic [63:0]        sq;
        logic [63:0]        term_v;
        logic [63:0]        prod;
        logic [63:0]        k;
        logic signed [63:0] sum;
        logic [63:0]        neg_sum;
        folded = {32'd0, angle} % {32'd0, DEG360_Q16};
        negate = 1'b0;
        if (folded >= {32'd0, DEG270_Q16})
            folded = {32'd0, DEG360_Q16} - folded;
        if (folded >= {32'd0, DEG180_Q16})
        begin
            folded = folded - {32'd0, DEG180_Q16};
            negate = 1'b1;
        end
        if (folded >= {32'd0, DEG90_Q16})
        begin
            folded = {32'd0, DEG180_Q16} - folded;
            negate = 1'b1;
        end
        rad_k = (64'h3243F6A8885A308D >> 14) / 64'd180;
        rad62 = {64'd0, folded} * {64'd0, rad_k};
        rad30 = rad62[95:32] + {63'd0, rad62[31]};
        sq = (rad30 * rad30 + (64'd1 << 29)) >> 30;
        term_v = 64'd1 << 30;
        sum = 64'sd1 <<< 30;
        for (int n = 1; n < TERMS; n++)
        begin
            k = 64'(2 * n - 1) * 64'(2 * n);
            prod = (term_v * sq + (64'd1 << 29)) >> 30;
            term_v = (prod + k / 2) / k;
            if (n % 2 == 1)
                sum = sum - $signed(term_v);
            else
                sum = sum + $signed(term_v);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 <<< 30))
            sum = 64'sd1 <<< 30;
        neg_sum = 64'd0 - sum;
        return negate ? neg_sum[31:0] : sum[31:0];
    endfunction

    assign pending = cosine_due_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] due;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (cosine_due_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %0d", $time, cosine);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    due = cosine_due_q.pop_front();
                    if (cosine !== due)
                    begin
                        $display("%0t: cosine mismatch, expected %0d, actual %0d",
                                 $time, due, cosine);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                cosine_due_q.push_back(predict_cosine(angle_degrees));
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives angles into the cosine block and gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cdt_pkg::*;

    localparam int LATENCY = 9 + 1 + 3 + 3 * (TERMS - 1) + 1;
    localparam int RANDOM_WORDS = 1400;
    localparam longint CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        angle_degrees;
    logic               done;
    logic signed [31:0] cosine;
    int                 fail_count;
    int                 pending;
    longint             cycle_count = 0;

    cosine_degrees_taylor_top u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .angle_degrees(angle_degrees),
        .done(done),
        .cosine(cosine)
    );

    cosine_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .angle_degrees(angle_degrees),
        .done(done),
        .cosine(cosine),
        .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cosine_degrees_taylor_top test failed");
            $finish;
        end
    end

    // Hold the word until accepted; idle at random unless told not to.
    task automatic send_angle(input logic [31:0] a, input bit no_idle);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        angle_degrees <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] random_angle();
        logic [31:0] deg;
        case ($urandom_range(5))
            0: return $urandom();
            1: return ($urandom_range(359) << 16) | $urandom_range(65535);
            2:
            begin
                deg = 32'($urandom_range(4) * 90);
                return (deg << 16) + 32'($urandom_range(4)) - 32'd2;
            end
            3: return 32'($urandom_range(181)) * DEG360_Q16 + ($urandom() & 32'h01FF_FFFF);
            4: return 32'hFFFF_FFFF - $urandom_range(1 << 20);
            default: return $urandom_range(65535) << 16;
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        rst_n = 1'b0;
        start = 1'b0;
        angle_degrees = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{32'd0, 32'hFFFF_FFFF, 32'd1, DEG90_Q16, DEG90_Q16 - 1, DEG90_Q16 + 1,
                     DEG180_Q16, DEG180_Q16 - 1, DEG270_Q16, DEG270_Q16 - 1,
                     DEG270_Q16 + 1, DEG360_Q16, DEG360_Q16 - 1, DEG360_Q16 + 1,
                     32'd45 << 16, 32'd60 << 16, 32'd135 << 16, 32'd225 << 16,
                     32'd315 << 16, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'hFFFF_0000, 32'h0000_FFFF};
        foreach (directed[i])
            send_angle(directed[i], 1'b0);

        // Drain fully before the random part.
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < RANDOM_WORDS; i++)
            send_angle(random_angle(), i >= 400 && i < 700);
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("cosine_degrees_taylor_top test passed");
        else
            $display("cosine_degrees_taylor_top test failed");
        $finish;
    end
endmodule

// ----- sim.f -----
src/cdt_pkg.sv
src/cdt_reduce.sv
src/cdt_rad.sv
src/cdt_term.sv
src/cosine_degrees_taylor_top.sv
tb/cosine_checker.sv
tb/tb_top.sv
